// ===== hdl/klm_pkg.sv =====
package klm_pkg;

  localparam int NUM_KEYWORDS = 6;
  localparam int WINDOW_LEN   = 19;
  localparam int TABLE_SIZE   = 6;
  localparam int KW_MAX       = 19;

  // keywords actually compared, never more than the table holds
  localparam int NUM_ACTIVE = (NUM_KEYWORDS < TABLE_SIZE) ? NUM_KEYWORDS : TABLE_SIZE;
  // byte positions that can take part in a compare
  localparam int CMP_LEN    = (KW_MAX < WINDOW_LEN) ? KW_MAX : WINDOW_LEN;
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
  localparam int KW_LEN_W   = $clog2(KW_MAX + 1);
  localparam int IDX_W      = 3;

  typedef logic [7:0] char_t;

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_QUEST = 8'h3F;
  localparam char_t CH_BANG  = 8'h21;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_SEMI  = 8'h3B;
  localparam char_t CH_COMMA = 8'h2C;
  localparam char_t CH_LC_A  = 8'h61;
  localparam char_t CH_LC_Z  = 8'h7A;
  localparam char_t CASE_OFS = 8'h20;

  // String literals are right-justified: the last character sits in byte 0,
  // so byte j of a keyword lines up with byte j of the window (newest first).
  localparam logic [KW_MAX*8-1:0] KW_STR [TABLE_SIZE] = '{
    "WHAT IS YOUR NAME",
    "HI",
    "HOW ARE YOU",
    "WHO ARE YOU",
    "ARE YOU INTELLIGENT",
    "ARE YOU REAL"
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [TABLE_SIZE] = '{
    KW_LEN_W'(17), KW_LEN_W'(2), KW_LEN_W'(11),
    KW_LEN_W'(11), KW_LEN_W'(19), KW_LEN_W'(12)
  };

  typedef struct packed {
    char_t text_byte;
    logic  line_end;
  } klm_in_t;

  typedef struct packed {
    logic             match_found;
    logic [IDX_W-1:0] match_index;
  } klm_out_t;

  function automatic logic is_punct(input char_t c);
    return (c == CH_QUEST) || (c == CH_BANG) || (c == CH_DOT) ||
           (c == CH_SEMI) || (c == CH_COMMA);
  endfunction

  function automatic char_t to_upper(input char_t c);
    if (c >= CH_LC_A && c <= CH_LC_Z) begin
      return c - CASE_OFS;
    end
    return c;
  endfunction

endpackage

// ===== hdl/keyword_line_matcher.sv =====
// Path: an accepted line_end beat goes into the input register, then the match logic
//   loads its result into the result register, which drives the result beat.
// Throughput: one input beat per cycle, sustained; a line_end beat waits in the
//   input register only while the result register is full and stalled.
// Reset (rst_n low, synchronous): window, fill count, previous byte, hit flags
//   and all valid flags clear; no result is pending.
module keyword_line_matcher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  klm_pkg::klm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output klm_pkg::klm_out_t out_data
);
  import klm_pkg::*;

  // ---------------- input register ----------------
  logic    s1_valid_r, s1_valid_nxt;
  klm_in_t s1_data_r;
  logic    s1_fire;
  logic    out_free;
  logic    in_accept;

  // result slot can take a new beat this cycle
  assign out_free  = !out_valid || !out_stall;
  // non-final bytes never need the result slot, so they always move on
  assign s1_fire   = s1_valid_r && (!s1_data_r.line_end || out_free);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_accept) begin
      s1_data_r <= in_data;
    end
  end

  // ---------------- line state ----------------
  logic [WINDOW_LEN*8-1:0] window_r, window_nxt;   // byte 0 = newest char
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  char_t                   prev_r, prev_nxt;
  logic [TABLE_SIZE-1:0]   hits_r, hits_nxt;

  logic  double_space;
  logic  push;
  char_t norm_char;
  logic [WINDOW_LEN*8-1:0] win_shift;
  logic [FILL_W-1:0]       fill_shift;
  logic [TABLE_SIZE-1:0]   hit_now;
  logic [TABLE_SIZE-1:0]   hits_all;
  logic                    kw_ok;

  klm_out_t res_nxt;

  always_comb begin
    // normalize the raw byte
    double_space = (s1_data_r.text_byte == CH_SPACE) && (prev_r == CH_SPACE);
    push         = !double_space && !is_punct(s1_data_r.text_byte);
    norm_char    = to_upper(s1_data_r.text_byte);

    // window as it stands after this byte
    win_shift  = window_r;
    fill_shift = fill_r;
    if (push) begin
      win_shift = {window_r[(WINDOW_LEN-1)*8-1:0], norm_char};
      if (fill_r < FILL_W'(WINDOW_LEN)) begin
        fill_shift = fill_r + FILL_W'(1);
      end
    end

    // parallel compare of every keyword ending at the newest char
    hit_now = '0;
    for (int i = 0; i < NUM_ACTIVE; i++) begin
      kw_ok = (int'(KW_LEN[i]) <= WINDOW_LEN) && (KW_LEN[i] != '0) &&
              (int'(KW_LEN[i]) <= int'(fill_shift));
      for (int j = 0; j < CMP_LEN; j++) begin
        if (j < int'(KW_LEN[i]) && win_shift[j*8 +: 8] != KW_STR[i][j*8 +: 8]) begin
          kw_ok = 1'b0;
        end
      end
      hit_now[i] = push && kw_ok;
    end
    hits_all = hits_r | hit_now;

    // lowest hit index wins
    res_nxt.match_found = |hits_all;
    res_nxt.match_index = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (hits_all[i]) begin
        res_nxt.match_index = IDX_W'(i);
      end
    end

    // commit, and clear everything once the line is reported
    window_nxt = window_r;
    fill_nxt   = fill_r;
    prev_nxt   = prev_r;
    hits_nxt   = hits_r;
    if (s1_fire) begin
      if (s1_data_r.line_end) begin
        window_nxt = '0;
        fill_nxt   = '0;
        prev_nxt   = '0;
        hits_nxt   = '0;
      end else begin
        window_nxt = win_shift;
        fill_nxt   = fill_shift;
        hits_nxt   = hits_all;
        if (!double_space) begin
          prev_nxt = s1_data_r.text_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r   <= '0;
      prev_r   <= '0;
      hits_r   <= '0;
    end else begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
      prev_r   <= prev_nxt;
      hits_r   <= hits_nxt;
    end
  end

  // ---------------- result register ----------------
  logic     out_valid_r, out_valid_nxt;
  klm_out_t out_data_r;
  logic     res_load;

  assign res_load = s1_fire && s1_data_r.line_end;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_load) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/klm_checker.sv =====
module klm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input klm_pkg::klm_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input klm_pkg::klm_out_t out_data
);
  import klm_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no hit means index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.match_found |-> out_data.match_index == '0)
    else $error("index nonzero without a hit");

  // index stays inside the keyword table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_data.match_index) < NUM_ACTIVE)
    else $error("index beyond keyword table");

  // the input side only stalls while a beat is held in the input register,
  // which needs an accepted beat on the cycle before the first stall
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid) || $past(in_stall))
    else $error("input stall with nothing held");

endmodule

bind keyword_line_matcher klm_checker u_klm_checker (.*);

// ===== tb/tb_keyword_line_matcher.sv =====
`timescale 1ns / 100ps

module tb_keyword_line_matcher;
  import klm_pkg::*;

  // local view of the scan geometry
  localparam int WIN_LEN     = WINDOW_LEN;
  localparam int KW_COUNT    = TABLE_SIZE;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;    // extra wait after the last result is checked
  localparam int IDLE_PCT    = 28;

  localparam char_t SP       = 8'h20;
  localparam char_t LC_A     = 8'h61;
  localparam char_t LC_Z     = 8'h7A;
  localparam char_t CASE_GAP = 8'h20;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  klm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  klm_out_t out_data;

  keyword_line_matcher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Keywords in table order; a lower index wins when several hit.
  string kw_text [KW_COUNT] = '{
    "WHAT IS YOUR NAME", "HI", "HOW ARE YOU",
    "WHO ARE YOU", "ARE YOU INTELLIGENT", "ARE YOU REAL"
  };
  // marks that are stripped before the window
  char_t marks [5] = '{8'h3F, 8'h21, 8'h2E, 8'h3B, 8'h2C};

  // Scanner state mirror: window is newest character first.
  char_t           win [WIN_LEN];
  int              win_fill;
  char_t           prev_raw;
  logic [KW_COUNT-1:0] kw_hits;

  klm_out_t line_results [$];   // per-line verdicts still owed by the block
  int       fail_count  = 0;
  int       beats_sent  = 0;
  int       cycle_count = 0;
  bit       tx_idle_on  = 1'b1;
  bit       rx_idle_on  = 1'b1;
  int       hold_req    = 0;    // long receiver hold-off, picked up by the sink
  int       hold_left   = 0;

  function automatic void clear_line_state();
    for (int j = 0; j < WIN_LEN; j++) win[j] = '0;
    win_fill = 0;
    prev_raw = '0;
    kw_hits  = '0;
  endfunction

  function automatic bit is_mark(char_t b);
    bit m;
    m = 1'b0;
    for (int j = 0; j < 5; j++) if (b == marks[j]) m = 1'b1;
    return m;
  endfunction

  // Advance the scanner by one raw byte; returns 1 when the line closes
  // and verdict holds what the block must report.
  function automatic bit scan_byte(char_t b, bit last, output klm_out_t verdict);
    char_t c;
    bit    hit;
    int    len;
    verdict = '0;
    // a space right after a raw space is swallowed, marks still count as raw
    if (!(b == SP && prev_raw == SP)) begin
      if (!is_mark(b)) begin
        c = b;
        if (c >= LC_A && c <= LC_Z) c = c - CASE_GAP;
        for (int j = WIN_LEN - 1; j > 0; j--) win[j] = win[j-1];
        win[0] = c;
        if (win_fill < WIN_LEN) win_fill++;
        // every keyword that ends on the newest character
        for (int i = 0; i < NUM_ACTIVE; i++) begin
          len = kw_text[i].len();
          if (len == 0 || len > WIN_LEN || len > win_fill) continue;
          hit = 1'b1;
          for (int k = 0; k < len; k++)
            if (win[len-1-k] != char_t'(kw_text[i][k])) hit = 1'b0;
          if (hit) kw_hits[i] = 1'b1;
        end
      end
      prev_raw = b;
    end
    if (!last) return 1'b0;
    verdict.match_found = (kw_hits != '0);
    for (int i = KW_COUNT - 1; i >= 0; i--)
      if (kw_hits[i]) verdict.match_index = IDX_W'(i);
    clear_line_state();
    return 1'b1;
  endfunction

  // One input beat: hold it until taken, then predict, then maybe idle.
  task automatic send_beat(input char_t b, input bit last);
    klm_in_t  beat;
    klm_out_t verdict;
    beat.text_byte = b;
    beat.line_end  = last;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    beats_sent++;
    if (scan_byte(b, last, verdict)) line_results = {line_results, verdict};
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++)
      send_beat(char_t'(s[k]), k == s.len() - 1);
  endtask

  // Mostly keyword-bearing lines in random case, with extra spaces and
  // stray marks that normalization must strip; some are mangled or noise.
  task automatic send_random_line();
    char_t line [$];
    string kw;
    char_t c;
    int    kind;
    repeat ($urandom_range(1, 4)) begin
      kind = $urandom_range(99);
      if (line.size() != 0) begin
        line = {line, SP};
        if ($urandom_range(3) == 0) line = {line, SP};
      end
      if (kind < 60) begin
        kw = kw_text[$urandom_range(KW_COUNT - 1)];
        for (int k = 0; k < kw.len(); k++) begin
          c = char_t'(kw[k]);
          if (c != SP && $urandom_range(1)) c = c + CASE_GAP;
          if ($urandom_range(15) == 0) line = {line, marks[$urandom_range(4)]};
          if ($urandom_range(19) != 0) line = {line, c};   // else drop: broken keyword
          if (c == SP && $urandom_range(4) == 0) line = {line, SP};
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 6)) begin
          c = char_t'($urandom_range(8'h41, 8'h5A));
          if ($urandom_range(1)) c = c + CASE_GAP;
          line = {line, c};
        end
      end else begin
        repeat ($urandom_range(1, 3)) line = {line, char_t'($urandom_range(255))};
      end
    end
    if ($urandom_range(3) == 0) line = {line, marks[$urandom_range(4)]};
    for (int k = 0; k < line.size(); k++)
      send_beat(line[k], k == line.size() - 1);
  endtask

  task automatic test_directed_lines();
    send_text("hI");                    // short keyword, mixed case
    send_text("What is your name?");    // line end on a stripped mark
    send_text("how  are you");          // doubled space collapses
    send_text("ARE YOU INTELLIGENT");   // keyword fills the whole window
    send_text("who are you");
    send_text("are you real hi");       // two hits, lower index reported
    send_text("HOW , ARE YOU");         // space after a mark is kept: no hit
    send_text("xHI");                   // keyword inside a word still hits
    send_text(",.;?!");                 // everything stripped
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h80, 1'b0);
    send_beat(8'h48, 1'b0);
    send_beat(8'h7F, 1'b0);             // control byte breaks the keyword
    send_beat(8'h49, 1'b1);
  endtask

  task automatic test_random_text(input int n_beats);
    int stop_at;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) send_random_line();
  endtask

  // No gaps on either side: back-to-back beats and results.
  task automatic test_steady_stream();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_text(250);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Sink holds off while short lines keep coming, so results back up
  // into the block and it must stall the input side.
  task automatic test_output_hold();
    tx_idle_on = 1'b0;
    hold_req   = 150;
    repeat (40) send_text("hi");
    repeat (20) send_text("ho");
    tx_idle_on = 1'b1;
  endtask

  // Result sink: random stalls, plus the long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_req - 1;
      hold_req  = 0;
    end else begin
      out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Result check against the oldest outstanding line verdict.
  always @(posedge clk) begin
    klm_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (line_results.size() == 0) begin
        $error("result beat with no line outstanding: found=%0d index=%0d",
               out_data.match_found, out_data.match_index);
        fail_count++;
      end else begin
        want = line_results.pop_front();
        if (out_data.match_found !== want.match_found) begin
          $error("match_found: expected %0d, got %0d",
                 want.match_found, out_data.match_found);
          fail_count++;
        end
        if (out_data.match_index !== want.match_index) begin
          $error("match_index: expected %0d, got %0d",
                 want.match_index, out_data.match_index);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clear_line_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lines();
    test_random_text(360);
    test_steady_stream();
    test_output_hold();
    test_random_text(300);
    in_valid <= 1'b0;

    while (line_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/klm_pkg.sv
hdl/keyword_line_matcher.sv
hdl/klm_checker.sv
tb/tb_keyword_line_matcher.sv
